[src/ntgs_pkg.sv]
// ----------------------------------------------------------------------------
// ntgs_pkg
// Shared constants and types for the gated nearest-target selector.
// ----------------------------------------------------------------------------
package ntgs_pkg;

  localparam int CoordBitsDefault = 12;
  localparam int FrameBits        = 13;
  localparam int ScoreBits        = 16;

  localparam int QueueDepth  = 4;
  localparam int ResultDepth = 2;

  // gate: 100 * d2 > 49 * (W*W + H*H)
  localparam int GateScale = 100;
  localparam int GateLimit = 49;

  localparam logic [FrameBits-1:0] FrameWidthReset  = 13'd640;
  localparam logic [FrameBits-1:0] FrameHeightReset = 13'd480;

  typedef enum logic [0:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_index_t;

endpackage

[src/ntgs_fifo.sv]
// ----------------------------------------------------------------------------
// ntgs_fifo
// Small register queue with push/full and pop/empty, head always on dout.
// ----------------------------------------------------------------------------
module ntgs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AddrBits  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]     store [DEPTH];
  logic [AddrBits-1:0]  wr_ptr;
  logic [AddrBits-1:0]  rd_ptr;
  logic [CountBits-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == CountBits'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AddrBits'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AddrBits'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountBits'(DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

[src/ntgs_front.sv]
// ----------------------------------------------------------------------------
// ntgs_front
// Accepts detections, works out area and squared centre distance in two
// registered steps and pushes each classified item into the queue.
// ----------------------------------------------------------------------------
module ntgs_front #(
  parameter int COORD_BITS = ntgs_pkg::CoordBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          present,
  input  logic [COORD_BITS-1:0]         box_x,
  input  logic [COORD_BITS-1:0]         box_y,
  input  logic [COORD_BITS:0]           box_w,
  input  logic [COORD_BITS:0]           box_h,
  input  logic [ntgs_pkg::ScoreBits-1:0] score,
  input  logic                          prev_valid,
  input  logic [COORD_BITS+1:0]         prev_cx2,
  input  logic [COORD_BITS+1:0]         prev_cy2,
  input  logic                          last,
  output logic                          q_push,
  output logic [8*COORD_BITS+27:0]      q_entry,
  input  logic                          q_full
);

  localparam int CenBits  = COORD_BITS + 2;
  localparam int SqBits   = 2 * CenBits;
  localparam int AreaBits = 2 * COORD_BITS + 2;
  localparam int DistBits = SqBits + 1;

  logic                          a_valid;
  logic                          a_present;
  logic                          a_last;
  logic                          a_prev_valid;
  logic [COORD_BITS-1:0]         a_x;
  logic [COORD_BITS-1:0]         a_y;
  logic [COORD_BITS:0]           a_w;
  logic [COORD_BITS:0]           a_h;
  logic [ntgs_pkg::ScoreBits-1:0] a_score;
  logic [CenBits-1:0]            a_dx;
  logic [CenBits-1:0]            a_dy;

  logic                          b_valid;
  logic                          b_present;
  logic                          b_last;
  logic                          b_prev_valid;
  logic [COORD_BITS-1:0]         b_x;
  logic [COORD_BITS-1:0]         b_y;
  logic [COORD_BITS:0]           b_w;
  logic [COORD_BITS:0]           b_h;
  logic [ntgs_pkg::ScoreBits-1:0] b_score;
  logic [AreaBits-1:0]           b_area;
  logic [SqBits-1:0]             b_dx2;
  logic [SqBits-1:0]             b_dy2;

  logic                          a_ready;
  logic                          b_ready;
  logic [CenBits-1:0]            cx;
  logic [CenBits-1:0]            cy;
  logic [DistBits-1:0]           d2;

  assign b_ready = !b_valid || !q_full;
  assign a_ready = !a_valid || b_ready;
  assign full    = !a_ready;
  assign q_push  = b_valid && !q_full;

  assign cx = {box_x, 1'b0} + CenBits'(box_w);
  assign cy = {box_y, 1'b0} + CenBits'(box_h);
  assign d2 = DistBits'(b_dx2) + DistBits'(b_dy2);

  assign q_entry = {b_present, b_last, b_prev_valid, b_area, d2,
                    b_x, b_y, b_w, b_h, b_score};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= push;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  // centre offsets
  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_present    <= present;
      a_last       <= last;
      a_prev_valid <= prev_valid;
      a_x          <= box_x;
      a_y          <= box_y;
      a_w          <= box_w;
      a_h          <= box_h;
      a_score      <= score;
      a_dx         <= (cx >= prev_cx2) ? cx - prev_cx2 : prev_cx2 - cx;
      a_dy         <= (cy >= prev_cy2) ? cy - prev_cy2 : prev_cy2 - cy;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_present    <= a_present;
      b_last       <= a_last;
      b_prev_valid <= a_prev_valid;
      b_x          <= a_x;
      b_y          <= a_y;
      b_w          <= a_w;
      b_h          <= a_h;
      b_score      <= a_score;
      b_area       <= AreaBits'(a_w) * AreaBits'(a_h);
      b_dx2        <= SqBits'(a_dx) * SqBits'(a_dx);
      b_dy2        <= SqBits'(a_dy) * SqBits'(a_dy);
    end
  end

endmodule

[src/ntgs_back.sv]
// ----------------------------------------------------------------------------
// ntgs_back
// Keeps the largest and nearest candidates of the running list, applies the
// diagonal gate at list end and pushes the selection into the result queue.
// ----------------------------------------------------------------------------
module ntgs_back #(
  parameter int COORD_BITS = ntgs_pkg::CoordBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ntgs_pkg::FrameBits-1:0] frame_width,
  input  logic [ntgs_pkg::FrameBits-1:0] frame_height,
  input  logic                          q_empty,
  input  logic [8*COORD_BITS+27:0]      q_entry,
  output logic                          q_pop,
  output logic                          o_push,
  output logic [4*COORD_BITS+19:0]      o_data,
  input  logic                          o_full
);

  localparam int FB       = ntgs_pkg::FrameBits;
  localparam int SB       = ntgs_pkg::ScoreBits;
  localparam int AreaBits = 2 * COORD_BITS + 2;
  localparam int DistBits = 2 * COORD_BITS + 5;
  localparam int GeomBits = 4 * COORD_BITS + 2;
  localparam int DiagBits = 2 * FB + 7;
  localparam int NearBits = DistBits + 7;
  localparam int CmpBits  = (NearBits > DiagBits) ? NearBits : DiagBits;

  logic                e_present;
  logic                e_last;
  logic                e_prev_valid;
  logic [AreaBits-1:0] e_area;
  logic [DistBits-1:0] e_d2;
  logic [GeomBits-1:0] e_geom;
  logic [SB-1:0]       e_score;

  logic                any_seen;
  logic [AreaBits-1:0] lg_area;
  logic [GeomBits-1:0] lg_geom;
  logic [SB-1:0]       lg_score;
  logic [DistBits-1:0] nr_d2;
  logic [GeomBits-1:0] nr_geom;
  logic [SB-1:0]       nr_score;

  logic                lg_hit;
  logic                nr_hit;
  logic                seen_next;
  logic [AreaBits-1:0] lg_area_next;
  logic [GeomBits-1:0] lg_geom_next;
  logic [SB-1:0]       lg_score_next;
  logic [DistBits-1:0] nr_d2_next;
  logic [GeomBits-1:0] nr_geom_next;
  logic [SB-1:0]       nr_score_next;

  logic                fin_valid;
  logic                fin_ready;
  logic                fin_found;
  logic                fin_prev_valid;
  logic [DistBits-1:0] fin_nr_d2;
  logic [GeomBits-1:0] fin_nr_geom;
  logic [SB-1:0]       fin_nr_score;
  logic [GeomBits-1:0] fin_lg_geom;
  logic [SB-1:0]       fin_lg_score;

  logic [2*FB-1:0]     fw_sq;
  logic [2*FB-1:0]     fh_sq;
  logic [2*FB:0]       diag_sq;
  logic [DiagBits-1:0] diag_limit;

  logic                take;
  logic                far;
  logic                use_near;
  logic [CmpBits-1:0]  near_scaled;

  assign {e_present, e_last, e_prev_valid, e_area, e_d2, e_geom, e_score} = q_entry;

  assign fin_ready = !fin_valid || !o_full;
  assign take      = !q_empty && (!e_last || fin_ready);
  assign q_pop     = take;

  assign lg_hit    = e_present && (!any_seen || (e_area > lg_area));
  assign nr_hit    = e_present && (!any_seen || (e_d2 < nr_d2));
  assign seen_next = any_seen || e_present;

  assign lg_area_next  = lg_hit ? e_area  : lg_area;
  assign lg_geom_next  = lg_hit ? e_geom  : lg_geom;
  assign lg_score_next = lg_hit ? e_score : lg_score;
  assign nr_d2_next    = nr_hit ? e_d2    : nr_d2;
  assign nr_geom_next  = nr_hit ? e_geom  : nr_geom;
  assign nr_score_next = nr_hit ? e_score : nr_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      any_seen <= 1'b0;
    end else if (take) begin
      any_seen <= seen_next && !e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lg_area  <= lg_area_next;
      lg_geom  <= lg_geom_next;
      lg_score <= lg_score_next;
      nr_d2    <= nr_d2_next;
      nr_geom  <= nr_geom_next;
      nr_score <= nr_score_next;
    end
  end

  // diagonal limit, follows the frame registers
  always_ff @(posedge clk) begin
    fw_sq      <= (2*FB)'(frame_width) * (2*FB)'(frame_width);
    fh_sq      <= (2*FB)'(frame_height) * (2*FB)'(frame_height);
    diag_sq    <= (2*FB+1)'(fw_sq) + (2*FB+1)'(fh_sq);
    diag_limit <= DiagBits'(diag_sq) * DiagBits'(ntgs_pkg::GateLimit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_ready) begin
      fin_valid <= take && e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && e_last) begin
      fin_found      <= seen_next;
      fin_prev_valid <= e_prev_valid;
      fin_nr_d2      <= nr_d2_next;
      fin_nr_geom    <= nr_geom_next;
      fin_nr_score   <= nr_score_next;
      fin_lg_geom    <= lg_geom_next;
      fin_lg_score   <= lg_score_next;
    end
  end

  assign near_scaled = CmpBits'(fin_nr_d2) * CmpBits'(ntgs_pkg::GateScale);
  assign far         = near_scaled > CmpBits'(diag_limit);
  assign use_near    = fin_prev_valid && !far;

  assign o_push = fin_valid && !o_full;
  assign o_data = fin_found ?
                  {1'b1,
                   use_near ? fin_nr_geom  : fin_lg_geom,
                   use_near ? fin_nr_score : fin_lg_score,
                   use_near} : '0;

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && o_full |=> fin_valid)
    else $error("finished selection dropped while result queue full");

  a_list_clear: assert property (@(posedge clk) disable iff (rst)
    take && e_last |=> !any_seen)
    else $error("candidate state not cleared after list end");

  a_near_found: assert property (@(posedge clk) disable iff (rst)
    o_push && o_data[0] |-> o_data[GeomBits+SB+1])
    else $error("nearest flag without a selection");

endmodule

[src/nearest_target_gated_select.sv]
// ----------------------------------------------------------------------------
// nearest_target_gated_select
// Picks one target box from a streamed detection list: nearest to the
// previous target, or the largest box when the nearest one lies beyond the
// frame diagonal gate or there is no previous target.
// ----------------------------------------------------------------------------
// Usage
//   Input queue: drive one detection per transfer (push while full is low),
//   last marks the end of a list. An empty list is a single item with
//   present low and last high.
//   Result queue: one result per list. While empty is low the oldest result
//   is on found/sel_*/chose_nearest; pop takes it.
//   Configuration: wr_en/wr_index/wr_data write frame_width (index 0) or
//   frame_height (index 1); write only while idle, the block does not check.
// Timing
//   One detection per cycle sustained while full stays low. A result is
//   visible once the list's last item has passed both front stages, the
//   classify queue write, the gate stage and the result queue write.
// Reset
//   rst clears all queues and candidates; frame size returns to 640 x 480.
// Stall
//   A held pop fills the result queue, then the gate stage, then the
//   four-entry classify queue and front stages, after which full rises.
// ----------------------------------------------------------------------------
module nearest_target_gated_select #(
  parameter int COORD_BITS = ntgs_pkg::CoordBitsDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           present,
  input  logic [COORD_BITS-1:0]          box_x,
  input  logic [COORD_BITS-1:0]          box_y,
  input  logic [COORD_BITS:0]            box_w,
  input  logic [COORD_BITS:0]            box_h,
  input  logic [ntgs_pkg::ScoreBits-1:0] score,
  input  logic                           prev_valid,
  input  logic [COORD_BITS+1:0]          prev_cx2,
  input  logic [COORD_BITS+1:0]          prev_cy2,
  input  logic                           last,
  output logic                           empty,
  input  logic                           pop,
  output logic                           found,
  output logic [COORD_BITS-1:0]          sel_x,
  output logic [COORD_BITS-1:0]          sel_y,
  output logic [COORD_BITS:0]            sel_w,
  output logic [COORD_BITS:0]            sel_h,
  output logic [ntgs_pkg::ScoreBits-1:0] sel_score,
  output logic                           chose_nearest,
  input  logic                           wr_en,
  input  logic [0:0]                     wr_index,
  input  logic [ntgs_pkg::FrameBits-1:0] wr_data
);

  localparam int EntryBits = 8 * COORD_BITS + 28;
  localparam int OutBits   = 4 * COORD_BITS + 20;

  logic [ntgs_pkg::FrameBits-1:0] frame_width;
  logic [ntgs_pkg::FrameBits-1:0] frame_height;

  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  logic [EntryBits-1:0] q_din;
  logic [EntryBits-1:0] q_dout;

  logic                 o_push;
  logic                 o_full;
  logic [OutBits-1:0]   o_din;
  logic [OutBits-1:0]   o_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ntgs_pkg::FrameWidthReset;
      frame_height <= ntgs_pkg::FrameHeightReset;
    end else if (wr_en) begin
      unique case (ntgs_pkg::reg_index_t'(wr_index))
        ntgs_pkg::RegFrameWidth:  frame_width  <= wr_data;
        ntgs_pkg::RegFrameHeight: frame_height <= wr_data;
      endcase
    end
  end

  ntgs_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .present    (present),
    .box_x      (box_x),
    .box_y      (box_y),
    .box_w      (box_w),
    .box_h      (box_h),
    .score      (score),
    .prev_valid (prev_valid),
    .prev_cx2   (prev_cx2),
    .prev_cy2   (prev_cy2),
    .last       (last),
    .q_push     (q_push),
    .q_entry    (q_din),
    .q_full     (q_full)
  );

  ntgs_fifo #(
    .WIDTH(EntryBits),
    .DEPTH(ntgs_pkg::QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  ntgs_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_empty      (q_empty),
    .q_entry      (q_dout),
    .q_pop        (q_pop),
    .o_push       (o_push),
    .o_data       (o_din),
    .o_full       (o_full)
  );

  ntgs_fifo #(
    .WIDTH(OutBits),
    .DEPTH(ntgs_pkg::ResultDepth)
  ) u_result (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .din   (o_din),
    .full  (o_full),
    .pop   (pop),
    .dout  (o_dout),
    .empty (empty)
  );

  assign {found, sel_x, sel_y, sel_w, sel_h, sel_score, chose_nearest} = o_dout;

endmodule

[tb/nearest_target_gated_select_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_target_gated_select_tb
// Streams detection lists into the selector and checks every selected target
// against an in-bench prediction of the largest box, the nearest box and the
// diagonal distance gate. Directed lists cover empty lists, ties, extremes and
// the exact gate boundary, followed by frame-size sweeps, a back-pressure
// phase and a long stretch of random lists with random gaps on both sides.
// ----------------------------------------------------------------------------
module nearest_target_gated_select_tb;

  localparam int CB            = ntgs_pkg::CoordBitsDefault;
  localparam int FB            = ntgs_pkg::FrameBits;
  localparam int SB            = ntgs_pkg::ScoreBits;
  localparam int ITEM_TARGET   = 1250;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES  = 500000;

  typedef struct packed {
    bit          present;
    bit [CB-1:0] x;
    bit [CB-1:0] y;
    bit [CB:0]   w;
    bit [CB:0]   h;
    bit [15:0]   score;
    bit          prev_valid;
    bit [CB+1:0] pcx;
    bit [CB+1:0] pcy;
    bit          last;
  } detection_t;

  typedef struct packed {
    bit          found;
    bit [CB-1:0] x;
    bit [CB-1:0] y;
    bit [CB:0]   w;
    bit [CB:0]   h;
    bit [15:0]   score;
    bit          chose_nearest;
  } selection_t;

  logic          clk;
  logic          rst;
  logic          push;
  logic          full;
  logic          present;
  logic [CB-1:0] box_x;
  logic [CB-1:0] box_y;
  logic [CB:0]   box_w;
  logic [CB:0]   box_h;
  logic [SB-1:0] score;
  logic          prev_valid;
  logic [CB+1:0] prev_cx2;
  logic [CB+1:0] prev_cy2;
  logic          last;
  logic          empty;
  logic          pop;
  logic          found;
  logic [CB-1:0] sel_x;
  logic [CB-1:0] sel_y;
  logic [CB:0]   sel_w;
  logic [CB:0]   sel_h;
  logic [SB-1:0] sel_score;
  logic          chose_nearest;
  logic          wr_en;
  logic [0:0]    wr_index;
  logic [FB-1:0] wr_data;

  nearest_target_gated_select uut (.*);

  // predictor state
  bit [FB-1:0]        frame_w_cfg;
  bit [FB-1:0]        frame_h_cfg;
  bit                 seen_box;
  longint unsigned    big_area;
  longint unsigned    near_d2;
  selection_t         big_pick;
  selection_t         near_pick;
  selection_t         pending_selections[$];

  int  errors;
  int  items_sent;
  int  lists_closed;
  int  empty_lists;
  int  nearest_picks;
  int  largest_picks;
  int  full_stalls;
  int  frame_settings;
  int  cycle_count;
  int  pop_hold;
  bit  tx_idle_en;
  bit  rx_idle_en;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic detection_t det(bit p, bit [CB-1:0] x, bit [CB-1:0] y, bit [CB:0] w,
                                     bit [CB:0] h, bit [15:0] s, bit pv, bit [CB+1:0] pcx,
                                     bit [CB+1:0] pcy, bit l);
    detection_t d;
    d = '{p, x, y, w, h, s, pv, pcx, pcy, l};
    return d;
  endfunction

  task automatic clear_candidates();
    seen_box  = 1'b0;
    big_area  = 0;
    near_d2   = 0;
    big_pick  = '0;
    near_pick = '0;
  endtask

  task automatic track_detection(input detection_t d);
    longint unsigned area, cx, cy, dx, dy, d2, diag2;
    selection_t      cand;
    bit              use_near;
    if (d.present) begin
      area = 64'(d.w) * 64'(d.h);
      cx   = 2 * 64'(d.x) + 64'(d.w);
      cy   = 2 * 64'(d.y) + 64'(d.h);
      dx   = (cx >= 64'(d.pcx)) ? cx - 64'(d.pcx) : 64'(d.pcx) - cx;
      dy   = (cy >= 64'(d.pcy)) ? cy - 64'(d.pcy) : 64'(d.pcy) - cy;
      d2   = dx * dx + dy * dy;
      cand = '{1'b1, d.x, d.y, d.w, d.h, d.score, 1'b0};
      if (!seen_box || area > big_area) begin
        big_area = area;
        big_pick = cand;
      end
      if (!seen_box || d2 < near_d2) begin
        near_d2   = d2;
        near_pick = cand;
      end
      seen_box = 1'b1;
    end
    if (d.last) begin
      cand = '0;
      if (seen_box) begin
        diag2    = 64'(frame_w_cfg) * 64'(frame_w_cfg) + 64'(frame_h_cfg) * 64'(frame_h_cfg);
        use_near = d.prev_valid &&
                   !(64'(ntgs_pkg::GateScale) * near_d2 > 64'(ntgs_pkg::GateLimit) * diag2);
        cand     = use_near ? near_pick : big_pick;
        cand.chose_nearest = use_near;
        if (use_near) nearest_picks++;
        else largest_picks++;
      end else begin
        empty_lists++;
      end
      lists_closed++;
      pending_selections = {pending_selections, cand};
      clear_candidates();
    end
  endtask

  task automatic match_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d actual %0d", name, expv, actv);
      errors++;
    end
  endtask

  task automatic check_selection();
    selection_t want;
    if (pending_selections.size() == 0) begin
      $error("result transfer with no selection outstanding");
      errors++;
      return;
    end
    want = pending_selections.pop_front();
    match_field("found", 32'(want.found), 32'(found));
    match_field("sel_x", 32'(want.x), 32'(sel_x));
    match_field("sel_y", 32'(want.y), 32'(sel_y));
    match_field("sel_w", 32'(want.w), 32'(sel_w));
    match_field("sel_h", 32'(want.h), 32'(sel_h));
    match_field("sel_score", 32'(want.score), 32'(sel_score));
    match_field("chose_nearest", 32'(want.chose_nearest), 32'(chose_nearest));
  endtask

  // result side: random stalls plus long hold-offs on request
  initial begin
    int stall;
    stall    = 0;
    pop      = 1'b0;
    pop_hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_selection();
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic send_item(input detection_t d);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    present    <= d.present;
    box_x      <= d.x;
    box_y      <= d.y;
    box_w      <= d.w;
    box_h      <= d.h;
    score      <= d.score;
    prev_valid <= d.prev_valid;
    prev_cx2   <= d.pcx;
    prev_cy2   <= d.pcy;
    last       <= d.last;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    if (d.present || d.last) items_sent++;
    track_detection(d);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_selections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_size(bit [FB-1:0] fw, bit [FB-1:0] fh);
    wr_en    <= 1'b1;
    wr_index <= ntgs_pkg::RegFrameWidth;
    wr_data  <= fw;
    @(posedge clk);
    wr_index <= ntgs_pkg::RegFrameHeight;
    wr_data  <= fh;
    @(posedge clk);
    wr_en <= 1'b0;
    frame_w_cfg = fw;
    frame_h_cfg = fh;
    frame_settings++;
  endtask

  function automatic detection_t random_box(bit [CB+1:0] pcx, bit [CB+1:0] pcy);
    detection_t d;
    int         bx, by, off;
    d         = '0;
    d.present = 1'b1;
    d.w       = ($urandom_range(0, 9) == 0) ? (CB+1)'($urandom_range(0, 8191))
                                            : (CB+1)'($urandom_range(0, 600));
    d.h       = ($urandom_range(0, 9) == 0) ? (CB+1)'($urandom_range(0, 8191))
                                            : (CB+1)'($urandom_range(0, 600));
    d.score   = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 1) == 1) begin
      // close to the previous target, around the default gate radius
      off = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 800)) - 400;
      bx  = (int'(pcx) - int'(d.w)) / 2 + off;
      off = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 800)) - 400;
      by  = (int'(pcy) - int'(d.h)) / 2 + off;
      bx  = (bx < 0) ? 0 : (bx > 4095) ? 4095 : bx;
      by  = (by < 0) ? 0 : (by > 4095) ? 4095 : by;
    end else begin
      bx = $urandom_range(0, 4095);
      by = $urandom_range(0, 4095);
    end
    d.x = CB'(bx);
    d.y = CB'(by);
    return d;
  endfunction

  task automatic send_random_list(int max_len);
    int          len;
    bit [CB+1:0] pcx, pcy;
    detection_t  d;
    if ($urandom_range(0, 19) == 0) begin
      send_item(det(1'b0, CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095)),
                    (CB+1)'($urandom_range(0, 8191)), (CB+1)'($urandom_range(0, 8191)),
                    16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    (CB+2)'($urandom_range(0, 16383)), (CB+2)'($urandom_range(0, 16383)),
                    1'b1));
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len)
                                       : $urandom_range(1, (max_len < 6) ? max_len : 6);
    pcx = (CB+2)'($urandom_range(0, 16383));
    pcy = (CB+2)'($urandom_range(0, 16383));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        pcx = (CB+2)'($urandom_range(0, 16383));
        pcy = (CB+2)'($urandom_range(0, 16383));
      end
      if ($urandom_range(0, 19) == 0) begin
        d = det(1'b0, CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095)),
                (CB+1)'($urandom_range(0, 8191)), (CB+1)'($urandom_range(0, 8191)),
                16'($urandom_range(0, 65535)), 1'b0, 14'd0, 14'd0, 1'b0);
      end else begin
        d = random_box(pcx, pcy);
      end
      d.prev_valid = ($urandom_range(0, 3) != 0);
      d.pcx        = pcx;
      d.pcy        = pcy;
      d.last       = (i == len - 1);
      send_item(d);
    end
  endtask

  task automatic test_directed_cases();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // empty list
    send_item(det(1'b0, 0, 0, 0, 0, 16'h0000, 1'b0, 0, 0, 1'b1));
    // closing marker without a box, its prev_valid enables the nearest rule
    send_item(det(1'b1, 10, 20, 30, 40, 16'h1234, 1'b1, 50, 80, 1'b0));
    send_item(det(1'b1, 2000, 2000, 100, 100, 16'h5678, 1'b1, 50, 80, 1'b0));
    send_item(det(1'b0, 4095, 4095, 8191, 8191, 16'hFFFF, 1'b1, 50, 80, 1'b1));
    // same list, no previous target on the closing item
    send_item(det(1'b1, 10, 20, 30, 40, 16'h1234, 1'b1, 50, 80, 1'b0));
    send_item(det(1'b1, 2000, 2000, 100, 100, 16'h5678, 1'b1, 50, 80, 1'b0));
    send_item(det(1'b0, 0, 0, 0, 0, 16'h0000, 1'b0, 50, 80, 1'b1));
    // field extremes, sizes beyond 4096
    send_item(det(1'b1, 4095, 4095, 8191, 8191, 16'hFFFF, 1'b1, 16383, 16383, 1'b1));
    send_item(det(1'b1, 0, 0, 0, 0, 16'h0000, 1'b1, 0, 0, 1'b1));
    // area tie, first wins
    send_item(det(1'b1, 100, 100, 20, 10, 16'h0001, 1'b0, 0, 0, 1'b0));
    send_item(det(1'b1, 300, 300, 10, 20, 16'h0002, 1'b0, 0, 0, 1'b1));
    // distance tie, first wins
    send_item(det(1'b1, 490, 495, 10, 10, 16'h00AA, 1'b1, 1000, 1000, 1'b0));
    send_item(det(1'b1, 500, 495, 10, 10, 16'h00BB, 1'b1, 1000, 1000, 1'b1));
    // gate boundary at 640 x 480: equal passes, one more gates
    send_item(det(1'b1, 0, 0, 0, 0, 16'h0C0C, 1'b1, 560, 0, 1'b1));
    send_item(det(1'b1, 0, 0, 0, 0, 16'h0D0D, 1'b1, 560, 1, 1'b1));
    // previous target moves within the list
    send_item(det(1'b1, 100, 100, 10, 10, 16'h1111, 1'b1, 212, 210, 1'b0));
    send_item(det(1'b1, 3000, 3000, 10, 10, 16'h2222, 1'b1, 6010, 6010, 1'b0));
    send_item(det(1'b0, 0, 0, 0, 0, 16'h0000, 1'b1, 0, 0, 1'b1));
    wait_idle();
  endtask

  task automatic test_frame_settings();
    bit [FB-1:0] fw_set[8];
    bit [FB-1:0] fh_set[8];
    int          n0;
    fw_set    = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'd1, 13'd4096, 13'd0, 13'd640};
    fh_set    = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'd4096, 13'd1, 13'd0, 13'd480};
    fw_set[6] = FB'($urandom_range(1, 4096));
    fh_set[6] = FB'($urandom_range(1, 4096));
    for (int i = 0; i < 8; i++) begin
      tx_idle_en = 1'($urandom_range(0, 1));
      rx_idle_en = 1'($urandom_range(0, 1));
      set_frame_size(fw_set[i], fh_set[i]);
      if (i == 0) begin
        // zero diagonal: only an exact hit keeps the nearest box
        send_item(det(1'b1, 50, 50, 10, 10, 16'h3333, 1'b1, 110, 110, 1'b1));
        send_item(det(1'b1, 50, 50, 10, 10, 16'h4444, 1'b1, 111, 110, 1'b1));
      end
      n0 = items_sent;
      while (items_sent - n0 < 50) send_random_list(8);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    int n0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    pop_hold   = 200;
    n0 = items_sent;
    while (items_sent - n0 < 40) send_random_list(1);
    wait_idle();
    rx_idle_en = 1'b1;
    n0 = items_sent;
    while (items_sent - n0 < 40) send_random_list(3);
    wait_idle();
  endtask

  task automatic test_random_lists();
    int n0;
    n0 = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent - n0 >= 60) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
        n0 = items_sent;
      end
      send_random_list(20);
    end
    wait_idle();
  endtask

  initial begin
    errors         = 0;
    items_sent     = 0;
    lists_closed   = 0;
    empty_lists    = 0;
    nearest_picks  = 0;
    largest_picks  = 0;
    full_stalls    = 0;
    frame_settings = 0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    frame_w_cfg    = ntgs_pkg::FrameWidthReset;
    frame_h_cfg    = ntgs_pkg::FrameHeightReset;
    clear_candidates();
    rst        = 1'b1;
    push       = 1'b0;
    present    = 1'b0;
    box_x      = '0;
    box_y      = '0;
    box_w      = '0;
    box_h      = '0;
    score      = '0;
    prev_valid = 1'b0;
    prev_cx2   = '0;
    prev_cy2   = '0;
    last       = 1'b0;
    wr_en      = 1'b0;
    wr_index   = '0;
    wr_data    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_frame_settings();
    test_backpressure();
    test_random_lists();

    $display("%0d detections in %0d lists (%0d empty): %0d nearest, %0d largest picks",
             items_sent, lists_closed, empty_lists, nearest_picks, largest_picks);
    $display("%0d frame sizes, %0d cycles held off by full", frame_settings, full_stalls);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
